// ===== src/fepl_pkg.sv =====
// Shared types and constants of the flash erase block planner.
package fepl_pkg;

    localparam int ADDR_W  = 29;
    localparam int START_W = 25;
    localparam int COUNT_W = 16;
    localparam int CAP_W   = 26;
    localparam int PROT_W  = 14;
    localparam int CODE_W  = 8;
    localparam int EADDR_W = 24;
    localparam int TMO_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    localparam logic [1:0] OP_START_CHECKED   = 2'd0;
    localparam logic [1:0] OP_START_UNCHECKED = 2'd1;
    localparam logic [1:0] OP_FINISH          = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROTECTED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_64K   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_32K   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_4K    = 3'd4;

    localparam logic [CAP_W-1:0]  CAPACITY_RST  = 26'd1048576;
    localparam logic [PROT_W-1:0] PROTECTED_RST = 14'd0;
    localparam logic [CODE_W-1:0] CMD_64K_RST   = 8'd216;
    localparam logic [CODE_W-1:0] CMD_32K_RST   = 8'd82;
    localparam logic [CODE_W-1:0] CMD_4K_RST    = 8'd32;

    localparam logic [1:0] SZ_4K  = 2'd0;
    localparam logic [1:0] SZ_32K = 2'd1;
    localparam logic [1:0] SZ_64K = 2'd2;

    localparam logic [ADDR_W-1:0] BYTES_4K  = 29'h0_1000;
    localparam logic [ADDR_W-1:0] BYTES_32K = 29'h0_8000;
    localparam logic [ADDR_W-1:0] BYTES_64K = 29'h1_0000;

    localparam logic [TMO_W-1:0] TMO_64K = 12'd3000;
    localparam logic [TMO_W-1:0] TMO_32K = 12'd1600;
    localparam logic [TMO_W-1:0] TMO_4K  = 12'd400;

    typedef struct packed {
        logic [CAP_W-1:0]  capacity_bytes;
        logic [PROT_W-1:0] protected_sectors;
        logic [CODE_W-1:0] cmd_erase_64k;
        logic [CODE_W-1:0] cmd_erase_32k;
        logic [CODE_W-1:0] cmd_erase_4k;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [START_W-1:0] start_address;
        logic [COUNT_W-1:0] sector_count;
        logic               erase_ok;
    } item_t;

    typedef struct packed {
        logic               issue;
        logic [CODE_W-1:0]  command_code;
        logic [EADDR_W-1:0] erase_address;
        logic [TMO_W-1:0]   timeout_ms;
        logic               finished;
        logic               success;
    } result_t;

endpackage

// ===== src/fepl_cfg.sv =====
// Configuration register file of the flash erase block planner.
module fepl_cfg
    import fepl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_CAPACITY:  cfg_next.capacity_bytes    = cfg_wdata[CAP_W-1:0];
                REG_PROTECTED: cfg_next.protected_sectors = cfg_wdata[PROT_W-1:0];
                REG_CMD_64K:   cfg_next.cmd_erase_64k     = cfg_wdata[CODE_W-1:0];
                REG_CMD_32K:   cfg_next.cmd_erase_32k     = cfg_wdata[CODE_W-1:0];
                REG_CMD_4K:    cfg_next.cmd_erase_4k      = cfg_wdata[CODE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.capacity_bytes    <= CAPACITY_RST;
            cfg_reg.protected_sectors <= PROTECTED_RST;
            cfg_reg.cmd_erase_64k     <= CMD_64K_RST;
            cfg_reg.cmd_erase_32k     <= CMD_32K_RST;
            cfg_reg.cmd_erase_4k      <= CMD_4K_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/fepl_plan.sv =====
// Job state and single-pass erase step decision of the flash erase block planner.
module fepl_plan
    import fepl_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output logic    has_result,
    output result_t result
);

    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [1:0]        step_reg, step_next;
    logic              active_reg, active_next;

    logic [ADDR_W-1:0] start_base;
    logic [ADDR_W-1:0] start_end;
    logic [ADDR_W-1:0] step_bytes;
    logic [ADDR_W-1:0] fin_cur;
    logic [ADDR_W-1:0] pick_cur;
    logic [ADDR_W-1:0] pick_end;
    logic [ADDR_W-1:0] left;
    logic [CAP_W-1:0]  prot_bytes;
    logic [CAP_W-1:0]  addr_ext;
    logic              bounds_fail;
    logic              is_start;
    logic [1:0]        pick_size;
    logic [CODE_W-1:0] pick_code;
    logic [TMO_W-1:0]  pick_tmo;

    always_comb begin
        is_start   = (item.opcode == OP_START_CHECKED) || (item.opcode == OP_START_UNCHECKED);
        start_base = {4'b0, item.start_address[START_W-1:12], 12'b0};
        start_end  = start_base + {1'b0, item.sector_count, 12'b0};
        prot_bytes = {cfg.protected_sectors, 12'b0};
        addr_ext   = {1'b0, item.start_address};
        bounds_fail = (addr_ext < prot_bytes) || (addr_ext >= cfg.capacity_bytes);

        unique case (step_reg)
            SZ_64K:  step_bytes = BYTES_64K;
            SZ_32K:  step_bytes = BYTES_32K;
            default: step_bytes = BYTES_4K;
        endcase
        fin_cur = cur_reg + step_bytes;

        pick_cur = is_start ? start_base : fin_cur;
        pick_end = is_start ? start_end : end_reg;
        left     = pick_end - pick_cur;

        priority if (left >= BYTES_64K && pick_cur[15:0] == 16'd0) begin
            pick_size = SZ_64K;
            pick_code = cfg.cmd_erase_64k;
            pick_tmo  = TMO_64K;
        end else if (left >= BYTES_32K && pick_cur[14:0] == 15'd0) begin
            pick_size = SZ_32K;
            pick_code = cfg.cmd_erase_32k;
            pick_tmo  = TMO_32K;
        end else begin
            pick_size = SZ_4K;
            pick_code = cfg.cmd_erase_4k;
            pick_tmo  = TMO_4K;
        end
    end

    always_comb begin
        cur_next    = cur_reg;
        end_next    = end_reg;
        step_next   = step_reg;
        active_next = active_reg;
        has_result  = 1'b0;
        result      = '0;

        unique case (item.opcode)
            OP_START_CHECKED, OP_START_UNCHECKED: begin
                has_result = 1'b1;
                if (item.sector_count == '0 ||
                    (item.opcode == OP_START_CHECKED && bounds_fail)) begin
                    active_next     = 1'b0;
                    result.finished = 1'b1;
                end else begin
                    cur_next             = start_base;
                    end_next             = start_end;
                    step_next            = pick_size;
                    active_next          = 1'b1;
                    result.issue         = 1'b1;
                    result.command_code  = pick_code;
                    result.erase_address = pick_cur[EADDR_W-1:0];
                    result.timeout_ms    = pick_tmo;
                end
            end
            OP_FINISH: begin
                if (active_reg) begin
                    has_result = 1'b1;
                    if (!item.erase_ok) begin
                        active_next     = 1'b0;
                        result.finished = 1'b1;
                    end else begin
                        cur_next = fin_cur;
                        if (fin_cur < end_reg) begin
                            step_next            = pick_size;
                            result.issue         = 1'b1;
                            result.command_code  = pick_code;
                            result.erase_address = pick_cur[EADDR_W-1:0];
                            result.timeout_ms    = pick_tmo;
                        end else begin
                            active_next     = 1'b0;
                            result.finished = 1'b1;
                            result.success  = 1'b1;
                        end
                    end
                end
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg    <= '0;
            end_reg    <= '0;
            step_reg   <= SZ_4K;
            active_reg <= 1'b0;
        end else if (advance) begin
            cur_reg    <= cur_next;
            end_reg    <= end_next;
            step_reg   <= step_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== src/flash_erase_block_planner.sv =====
// Top level of the flash erase block planner: input word register, planner, result register.
// An accepted word waits in the input register; its result word is held in the result register.
// Throughput: one input word per cycle; the input register drains whenever the result
// register is empty or being taken, so a stalled result holds one word on each side.
// Reset clears both valid flags and the job state, and loads the configuration defaults.
// Configuration writes take effect at the next clock edge.
module flash_erase_block_planner
    import fepl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,  // start_address, sector_count, erase_ok, zero fill
    input  logic [1:0]            s_tuser,  // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,  // command_code, erase_address, timeout_ms, success, zero fill
    output logic                  m_tuser,  // issue
    output logic                  m_tlast,  // finished
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    has_result;
    result_t result;

    fepl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fepl_plan u_plan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item       (in_item_reg),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.opcode        <= s_tuser;
            in_item_reg.start_address <= s_tdata[24:0];
            in_item_reg.sector_count  <= s_tdata[40:25];
            in_item_reg.erase_ok      <= s_tdata[41];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= has_result;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.issue;
    assign m_tlast  = out_res_reg.finished;
    assign m_tdata  = {3'b0, out_res_reg.success, out_res_reg.timeout_ms,
                       out_res_reg.erase_address, out_res_reg.command_code};

endmodule

// ===== tb/tb_flash_erase_block_planner.sv =====
// Self-checking testbench for the flash erase block planner: directed and random words.
`timescale 1ns / 100ps

module tb_flash_erase_block_planner
    import fepl_pkg::*;
();

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         SETTLE      = 6;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata   = '0;  // start_address, sector_count, erase_ok, zero fill
    logic [1:0]            s_tuser   = '0;  // opcode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [47:0]           m_tdata;  // command_code, erase_address, timeout_ms, success, zero fill
    logic                  m_tuser;  // issue
    logic                  m_tlast;  // finished
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    cfg_t              plan_cfg = '{CAPACITY_RST, PROTECTED_RST, CMD_64K_RST, CMD_32K_RST,
                                    CMD_4K_RST};
    logic [ADDR_W-1:0] plan_cur  = '0;
    logic [ADDR_W-1:0] plan_end  = '0;
    logic [ADDR_W-1:0] plan_step = '0;
    bit                plan_busy = 1'b0;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      gap_pct        = 0;
    int      stall_pct      = 0;
    int      hold_req       = 0;
    int      hold_left      = 0;

    flash_erase_block_planner uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.issue         = m_tuser;
            got.command_code  = m_tdata[7:0];
            got.erase_address = m_tdata[31:8];
            got.timeout_ms    = m_tdata[43:32];
            got.finished      = m_tlast;
            got.success       = m_tdata[44];
            if (pending_results.size() == 0) begin
                $error("unexpected result word: issue %0d finished %0d", got.issue,
                       got.finished);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.issue !== want.issue) begin
                    $error("issue: expected %0d, actual %0d", want.issue, got.issue);
                    mismatch_count++;
                end
                if (got.command_code !== want.command_code) begin
                    $error("command_code: expected %0d, actual %0d", want.command_code,
                           got.command_code);
                    mismatch_count++;
                end
                if (got.erase_address !== want.erase_address) begin
                    $error("erase_address: expected %h, actual %h", want.erase_address,
                           got.erase_address);
                    mismatch_count++;
                end
                if (got.timeout_ms !== want.timeout_ms) begin
                    $error("timeout_ms: expected %0d, actual %0d", want.timeout_ms,
                           got.timeout_ms);
                    mismatch_count++;
                end
                if (got.finished !== want.finished) begin
                    $error("finished: expected %0d, actual %0d", want.finished, got.finished);
                    mismatch_count++;
                end
                if (got.success !== want.success) begin
                    $error("success: expected %0d, actual %0d", want.success, got.success);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic close_job(input logic ok, output result_t r);
        plan_busy = 1'b0;
        plan_step = '0;
        r = '{1'b0, '0, '0, '0, 1'b1, ok};
    endtask

    task automatic next_block(output result_t r);
        logic [ADDR_W-1:0] left;
        left = plan_end - plan_cur;
        if (left >= BYTES_64K && plan_cur[15:0] == 16'h0) begin
            plan_step = BYTES_64K;
            r = '{1'b1, plan_cfg.cmd_erase_64k, plan_cur[EADDR_W-1:0], TMO_64K, 1'b0, 1'b0};
        end else if (left >= BYTES_32K && plan_cur[14:0] == 15'h0) begin
            plan_step = BYTES_32K;
            r = '{1'b1, plan_cfg.cmd_erase_32k, plan_cur[EADDR_W-1:0], TMO_32K, 1'b0, 1'b0};
        end else begin
            plan_step = BYTES_4K;
            r = '{1'b1, plan_cfg.cmd_erase_4k, plan_cur[EADDR_W-1:0], TMO_4K, 1'b0, 1'b0};
        end
        plan_busy = 1'b1;
    endtask

    task automatic plan_word(input logic [1:0] op, input logic [START_W-1:0] addr,
                             input logic [COUNT_W-1:0] cnt, input logic ok,
                             output bit emit, output result_t r);
        logic [31:0] low_bound;
        low_bound = {18'd0, plan_cfg.protected_sectors} << 12;
        emit = 1'b1;
        r = '0;
        if (op == OP_START_CHECKED || op == OP_START_UNCHECKED) begin
            plan_busy = 1'b0;
            if (cnt == '0) begin
                close_job(1'b0, r);
            end else if (op == OP_START_CHECKED &&
                         ({7'd0, addr} < low_bound ||
                          {7'd0, addr} >= {6'd0, plan_cfg.capacity_bytes})) begin
                close_job(1'b0, r);
            end else begin
                plan_cur = {4'd0, addr[START_W-1:12], 12'h000};
                plan_end = plan_cur + ({13'd0, cnt} << 12);
                next_block(r);
            end
        end else if (op == OP_FINISH && plan_busy) begin
            if (!ok) begin
                close_job(1'b0, r);
            end else begin
                plan_cur = plan_cur + plan_step;
                if (plan_cur < plan_end)
                    next_block(r);
                else
                    close_job(1'b1, r);
            end
        end else begin
            emit = 1'b0;
        end
    endtask

    task automatic send_word(input logic [1:0] op, input logic [START_W-1:0] addr,
                             input logic [COUNT_W-1:0] cnt, input logic ok, output bit emit);
        result_t r;
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < gap_pct)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, ok, cnt, addr};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        plan_word(op, addr, cnt, ok, emit, r);
        if (emit)
            pending_results.push_back(r);
    endtask

    task automatic send(input logic [1:0] op, input logic [START_W-1:0] addr,
                        input logic [COUNT_W-1:0] cnt, input logic ok);
        bit emit;
        send_word(op, addr, cnt, ok, emit);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CAP_W-1:0] cap, input logic [PROT_W-1:0] prot,
                              input logic [CODE_W-1:0] c64, input logic [CODE_W-1:0] c32,
                              input logic [CODE_W-1:0] c4);
        logic [CFG_DATA_W-1:0] vals[5];
        logic [CFG_IDX_W-1:0]  idx[5];
        vals = '{CFG_DATA_W'(cap), CFG_DATA_W'(prot), CFG_DATA_W'(c64), CFG_DATA_W'(c32),
                 CFG_DATA_W'(c4)};
        idx  = '{REG_CAPACITY, REG_PROTECTED, REG_CMD_64K, REG_CMD_32K, REG_CMD_4K};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        plan_cfg = '{cap, prot, c64, c32, c4};
    endtask

    task automatic set_random_config();
        set_config(CAP_W'($urandom_range(33554432, 1048576)),
                   PROT_W'($urandom_range(3) == 0 ? $urandom_range(8192) : $urandom_range(64)),
                   CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom));
    endtask

    task automatic test_defaults();
        send(OP_START_CHECKED, 25'h0, 16'd1, 1'b0);
        send(OP_FINISH, 25'h0, 16'd0, 1'b1);
        send(OP_FINISH, 25'h1FFFFFF, 16'hFFFF, 1'b1);
        send(OP_UNUSED, 25'h1FFFFFF, 16'hFFFF, 1'b1);
    endtask

    task automatic test_zero_count();
        send(OP_START_CHECKED, 25'h1000, 16'd0, 1'b0);
        send(OP_START_UNCHECKED, 25'h1FFFFFF, 16'd0, 1'b1);
    endtask

    task automatic test_bounds();
        drain();
        set_config(CAPACITY_RST, 14'd16, CMD_64K_RST, CMD_32K_RST, CMD_4K_RST);
        send(OP_START_CHECKED, 25'h00FFFF, 16'd1, 1'b0);
        send(OP_START_CHECKED, 25'h010000, 16'd1, 1'b0);
        send(OP_START_CHECKED, 25'h0FFFFF, 16'd1, 1'b0);
        send(OP_START_CHECKED, 25'h100000, 16'd1, 1'b0);
        send(OP_START_UNCHECKED, 25'h1FFFFFF, 16'd2, 1'b0);
        send(OP_FINISH, 25'h0, 16'd0, 1'b0);
    endtask

    task automatic test_block_sizes();
        send(OP_START_UNCHECKED, 25'h017000, 16'd26, 1'b0);
        repeat (4) send(OP_FINISH, 25'h0, 16'd0, 1'b1);
        send(OP_START_CHECKED, 25'h020000, 16'd16, 1'b0);
        send(OP_FINISH, 25'h0, 16'd0, 1'b1);
    endtask

    task automatic test_abandon();
        send(OP_START_UNCHECKED, 25'h1FFFFFF, 16'hFFFF, 1'b0);
        repeat (2) send(OP_FINISH, 25'h0, 16'd0, 1'b1);
        send(OP_START_CHECKED, 25'h030000, 16'd3, 1'b0);
        send(OP_FINISH, 25'h0, 16'd0, 1'b0);
        send(OP_FINISH, 25'h0, 16'd0, 1'b1);
    endtask

    task automatic test_backpressure();
        drain();
        gap_pct   = 0;
        stall_pct = 0;
        hold_req  = 300;
        repeat (12) send(OP_START_UNCHECKED, START_W'($urandom), 16'd8, 1'b0);
        drain();
    endtask

    task automatic run_random(input int n_words);
        int                 done_words;
        int                 steps;
        bit                 emit;
        logic [1:0]         op;
        logic [START_W-1:0] addr;
        logic [COUNT_W-1:0] cnt;
        logic [31:0]        lo;
        logic [31:0]        hi;
        done_words = 0;
        while (done_words < n_words) begin
            if ($urandom_range(99) < 85) begin
                lo = {18'd0, plan_cfg.protected_sectors} << 12;
                hi = {6'd0, plan_cfg.capacity_bytes};
                op = $urandom_range(1) ? OP_START_CHECKED : OP_START_UNCHECKED;
                case ($urandom_range(4))
                    0: addr = START_W'($urandom);
                    1: addr = (lo < hi) ? START_W'($urandom_range(hi - 1, lo))
                                        : START_W'($urandom);
                    2: addr = START_W'($urandom) & 25'h1FFF000;
                    3: addr = START_W'($urandom) & 25'h1FF8000;
                    default: begin
                        case ($urandom_range(3))
                            0: addr = START_W'(lo - 1);
                            1: addr = START_W'(lo);
                            2: addr = START_W'(hi - 1);
                            default: addr = START_W'(hi);
                        endcase
                    end
                endcase
                case ($urandom_range(9))
                    0: cnt = '0;
                    1: cnt = COUNT_W'($urandom);
                    default: cnt = COUNT_W'($urandom_range(40, 1));
                endcase
                send_word(op, addr, cnt, 1'b0, emit);
                done_words += emit;
                steps = 0;
                while (plan_busy && steps < 48 && $urandom_range(29) != 0) begin
                    send_word(OP_FINISH, START_W'($urandom), COUNT_W'($urandom),
                              $urandom_range(39) != 0, emit);
                    done_words += emit;
                    steps++;
                end
            end else begin
                case ($urandom_range(2))
                    0: op = OP_UNUSED;
                    1: op = OP_FINISH;
                    default: op = 2'($urandom);
                endcase
                send_word(op, START_W'($urandom), COUNT_W'($urandom), 1'($urandom), emit);
                done_words += emit;
            end
        end
    endtask

    task automatic test_random();
        drain();
        gap_pct   = 0;
        stall_pct = 0;
        run_random(275);
        drain();
        set_config(26'd33554432, 14'd0, 8'd255, 8'd255, 8'd255);
        gap_pct   = 68;
        stall_pct = 0;
        run_random(275);
        drain();
        set_config(26'd1048576, 14'd8192, 8'd0, 8'd0, 8'd0);
        gap_pct   = 0;
        stall_pct = 68;
        run_random(275);
        drain();
        set_random_config();
        gap_pct   = 13;
        stall_pct = 13;
        run_random(275);
        drain();
        set_random_config();
        gap_pct   = 0;
        stall_pct = 0;
        run_random(275);
        drain();
        set_random_config();
        gap_pct   = 68;
        stall_pct = 68;
        run_random(275);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_zero_count();
        test_bounds();
        test_block_sizes();
        test_abandon();
        test_backpressure();
        test_random();
        drain();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
